// File: sv/yuv9p_pkg.sv
`timescale 1ns / 1ps

package yuv9p_pkg;

    // Line store sizing.
    localparam int MAX_WIDTH   = 2048;
    localparam int STORE_DEPTH = MAX_WIDTH / 4;
    localparam int COL_W       = $clog2(STORE_DEPTH);
    localparam int SUM_W       = 11;

    // Row position counters.
    localparam int BYTE_W = 12;
    localparam int ROWB_W = BYTE_W + 1;
    localparam int GRP_W  = BYTE_W - 3;
    localparam int CFGD_W = 12;

    // Result queue.
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int MAX_RESULTS = 3;
    localparam int READY_LEVEL = FIFO_DEPTH - 2 * MAX_RESULTS;

    // Input layouts.
    localparam logic [1:0] MODE_GRAY8 = 2'd0;
    localparam logic [1:0] MODE_422   = 2'd1;
    localparam logic [1:0] MODE_411   = 2'd2;

    // Output planes.
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_INPUT_MODE = 2'd0;
    localparam logic [1:0] REG_LINE_WIDTH = 2'd1;

    localparam logic [1:0]        MODE_RESET  = MODE_422;
    localparam logic [CFGD_W-1:0] WIDTH_RESET = 12'd640;

    // A 4:1:1 group is twelve bytes long; position 11 is its last byte.
    localparam logic [3:0] GROUP411_LAST = 4'd11;
    localparam logic [7:0] CHROMA_GRAY   = 8'd128;
    localparam logic [1:0] LAST_BAND_ROW = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0] plane;
        logic [7:0] sample;
        logic       last;
    } out_item_t;

    // One byte between the address stage and the update stage.
    typedef struct packed {
        logic             emit_y;
        logic             cb_op;
        logic             cr_op;
        logic             first;
        logic             emit_uv;
        logic             gray;
        logic             is411;
        logic [7:0]       data;
        logic [COL_W-1:0] col;
    } stage_t;

endpackage

// File: sv/packed_ycbcr_to_yuv9_planar_top.sv
`timescale 1ns / 1ps

// Packed video to YUV9 planar converter.
// Input channel (in_valid/in_ready/in_data): one byte of the packed raster per
// transfer, with frame_start set on the first byte of a frame.
// Output channel (out_valid/out_ready/out_data): one sample per transfer with
// its plane (Y, U or V); last marks the final sample caused by an input byte.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; index 0 selects the input layout, index 1 the line width in pixels.
// Write it only while no byte is in flight.
// Throughput: one input byte per cycle while the output keeps up. Each byte
// gives zero to three samples and the output port moves one per cycle, so
// the sustained rate is set by the output port and the eight-entry queue.
// A byte is registered into the update stage, where its line store read
// returns, and its samples are written into the queue and then offered.
// Chroma sums live in two 512-entry line stores with registered reads; the
// update stage writes back and forwards to a read of the same entry.
// Reset empties the queue, clears the row and band position and loads the
// default layout (4:2:2) and width (640). The line stores are not cleared.
// When the receiver stalls, the queue fills and in_ready drops.
module packed_ycbcr_to_yuv9_planar_top
    import yuv9p_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CFGD_W-1:0]   cfg_data
);

    logic [1:0]        mode_reg;
    logic [CFGD_W-1:0] width_reg;
    logic [BYTE_W-1:0] bir_reg, bir_next;
    logic [1:0]        rib_reg, rib_next;
    logic [3:0]        p12_reg, p12_next;
    logic [GRP_W-1:0]  g12_reg, g12_next;

    logic              s1_valid_reg;
    stage_t            s1_reg, s1_next;

    logic              fwd_cb_hit_reg, fwd_cr_hit_reg;
    logic [SUM_W-1:0]  fwd_cb_data_reg, fwd_cr_data_reg;

    out_item_t         fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]  count_reg, count_next;

    logic              accept, pop;
    logic [1:0]        mode;
    logic [CFGD_W-1:0] w_clamp, w_al;
    logic [ROWB_W-1:0] row_bytes, bir_inc;
    logic [BYTE_W-1:0] bir0, bir_a;
    logic [1:0]        rib0, rib_a;
    logic [3:0]        p12_0, p12_a;
    logic [GRP_W-1:0]  g12_0, g12_a;
    logic [2:0]        p8;

    logic              cb_re, cr_re, cb_we, cr_we;
    logic [SUM_W-1:0]  cb_q, cr_q, cb_base, cr_base, cb_sum, cr_sum;
    logic [7:0]        u_sample, v_sample;
    out_item_t         res [MAX_RESULTS];
    logic [1:0]        push_n;

    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INPUT_MODE: mode_reg  <= cfg_data[1:0];
                REG_LINE_WIDTH: width_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Layout 3 means nothing and behaves as gray8.
    assign mode = (mode_reg == MODE_422 || mode_reg == MODE_411) ? mode_reg : MODE_GRAY8;

    always_comb
    begin
        w_clamp = (width_reg > CFGD_W'(MAX_WIDTH)) ? CFGD_W'(MAX_WIDTH) : width_reg;
        if (mode == MODE_411)
        begin
            w_al = {w_clamp[CFGD_W-1:3], 3'b000};
            if (w_al < CFGD_W'(8))
            begin
                w_al = CFGD_W'(8);
            end
        end
        else
        begin
            w_al = {w_clamp[CFGD_W-1:2], 2'b00};
            if (w_al < CFGD_W'(4))
            begin
                w_al = CFGD_W'(4);
            end
        end
        unique case (mode)
            MODE_422: row_bytes = {w_al, 1'b0};
            MODE_411: row_bytes = ROWB_W'(w_al) + ROWB_W'(w_al >> 1);
            default:  row_bytes = ROWB_W'(w_al);
        endcase
    end

    // ---------------------------------------------------------------------
    // Address stage: position bookkeeping and byte decode
    // ---------------------------------------------------------------------
    always_comb
    begin
        bir0  = in_data.frame_start ? '0 : bir_reg;
        rib0  = in_data.frame_start ? '0 : rib_reg;
        p12_0 = in_data.frame_start ? '0 : p12_reg;
        g12_0 = in_data.frame_start ? '0 : g12_reg;

        // A row left too long by a width change starts over first.
        if (ROWB_W'(bir0) >= row_bytes)
        begin
            bir_a = '0;
            rib_a = rib0 + 2'd1;
            p12_a = '0;
            g12_a = '0;
        end
        else
        begin
            bir_a = bir0;
            rib_a = rib0;
            p12_a = p12_0;
            g12_a = g12_0;
        end

        bir_inc = ROWB_W'(bir_a) + ROWB_W'(1);
        if (bir_inc >= row_bytes)
        begin
            bir_next = '0;
            rib_next = rib_a + 2'd1;
            p12_next = '0;
            g12_next = '0;
        end
        else
        begin
            bir_next = bir_inc[BYTE_W-1:0];
            rib_next = rib_a;
            p12_next = (p12_a == GROUP411_LAST) ? 4'd0 : p12_a + 4'd1;
            g12_next = (p12_a == GROUP411_LAST) ? g12_a + GRP_W'(1) : g12_a;
        end

        p8      = bir_a[2:0];
        s1_next = '0;
        s1_next.data = in_data.data_byte;
        unique case (mode)
            MODE_422:
            begin
                s1_next.col     = COL_W'(bir_a >> 3);
                s1_next.emit_y  = !p8[0];
                s1_next.cb_op   = (p8 == 3'd1) || (p8 == 3'd5);
                s1_next.cr_op   = (p8 == 3'd3) || (p8 == 3'd7);
                s1_next.first   = (rib_a == 2'd0) && ((p8 == 3'd1) || (p8 == 3'd3));
                s1_next.emit_uv = (p8 == 3'd7) && (rib_a == LAST_BAND_ROW);
            end
            MODE_411:
            begin
                s1_next.is411   = 1'b1;
                s1_next.col     = COL_W'({g12_a, 1'b0} + GRP_W'(p12_a >= 4'd4));
                s1_next.cb_op   = (p12_a == 4'd0) || (p12_a == 4'd4);
                s1_next.cr_op   = (p12_a == 4'd2) || (p12_a == 4'd6);
                s1_next.emit_y  = !(s1_next.cb_op || s1_next.cr_op);
                s1_next.first   = (rib_a == 2'd0);
                s1_next.emit_uv = s1_next.cr_op && (rib_a == LAST_BAND_ROW);
            end
            default:
            begin
                s1_next.gray    = 1'b1;
                s1_next.emit_y  = 1'b1;
                s1_next.emit_uv = (rib_a == LAST_BAND_ROW) && (bir_a[1:0] == 2'd3);
            end
        endcase
    end

    assign cb_re = accept && (s1_next.cb_op || (s1_next.emit_uv && !s1_next.gray));
    assign cr_re = accept && s1_next.cr_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bir_reg      <= '0;
            rib_reg      <= '0;
            p12_reg      <= '0;
            g12_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                bir_reg <= bir_next;
                rib_reg <= rib_next;
                p12_reg <= p12_next;
                g12_reg <= g12_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // ---------------------------------------------------------------------
    // Line stores
    // ---------------------------------------------------------------------
    yuv9p_ram #(.WIDTH(SUM_W), .DEPTH(STORE_DEPTH)) u_cb_ram (
        .clk   (clk),
        .we    (cb_we),
        .waddr (s1_reg.col),
        .wdata (cb_sum),
        .re    (cb_re),
        .raddr (s1_next.col),
        .rdata (cb_q)
    );

    yuv9p_ram #(.WIDTH(SUM_W), .DEPTH(STORE_DEPTH)) u_cr_ram (
        .clk   (clk),
        .we    (cr_we),
        .waddr (s1_reg.col),
        .wdata (cr_sum),
        .re    (cr_re),
        .raddr (s1_next.col),
        .rdata (cr_q)
    );

    // A write landing in the same cycle as the read of that entry is
    // forwarded, since the store returns the old contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_cb_hit_reg <= 1'b0;
            fwd_cr_hit_reg <= 1'b0;
        end
        else
        begin
            if (cb_re)
            begin
                fwd_cb_hit_reg <= cb_we && (s1_reg.col == s1_next.col);
            end
            if (cr_re)
            begin
                fwd_cr_hit_reg <= cr_we && (s1_reg.col == s1_next.col);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cb_re)
        begin
            fwd_cb_data_reg <= cb_sum;
        end
        if (cr_re)
        begin
            fwd_cr_data_reg <= cr_sum;
        end
    end

    // ---------------------------------------------------------------------
    // Update stage
    // ---------------------------------------------------------------------
    assign cb_we   = s1_valid_reg && s1_reg.cb_op;
    assign cr_we   = s1_valid_reg && s1_reg.cr_op;
    assign cb_base = fwd_cb_hit_reg ? fwd_cb_data_reg : cb_q;
    assign cr_base = fwd_cr_hit_reg ? fwd_cr_data_reg : cr_q;
    assign cb_sum  = (s1_reg.first ? '0 : cb_base) + SUM_W'(s1_reg.data);
    assign cr_sum  = (s1_reg.first ? '0 : cr_base) + SUM_W'(s1_reg.data);

    always_comb
    begin
        if (s1_reg.gray)
        begin
            u_sample = CHROMA_GRAY;
            v_sample = CHROMA_GRAY;
        end
        else if (s1_reg.is411)
        begin
            u_sample = 8'(cb_base >> 2);
            v_sample = 8'(cr_sum >> 2);
        end
        else
        begin
            u_sample = 8'(cb_base >> 3);
            v_sample = 8'(cr_sum >> 3);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end
        push_n = 2'd0;
        if (s1_valid_reg)
        begin
            if (s1_reg.emit_y)
            begin
                res[0] = '{plane: PLANE_Y, sample: s1_reg.data, last: !s1_reg.emit_uv};
                push_n = 2'd1;
            end
            if (s1_reg.emit_uv)
            begin
                res[push_n]        = '{plane: PLANE_U, sample: u_sample, last: 1'b0};
                res[push_n + 2'd1] = '{plane: PLANE_V, sample: v_sample, last: 1'b1};
                push_n             = push_n + 2'd2;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------------
    assign count_next = count_reg + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (i < int'(push_n))
            begin
                fifo_mem_reg[wr_ptr_reg + FIFO_AW'(i)] <= res[i];
            end
        end
    end

    // Room for the byte in the update stage and for this one.
    assign in_ready  = count_reg <= (FIFO_AW + 1)'(READY_LEVEL);
    assign out_valid = count_reg != '0;
    assign out_data  = fifo_mem_reg[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_uv_source: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.emit_uv) |-> (s1_reg.cr_op || s1_reg.gray))
        else $error("chroma output without a Cr update");

    a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted byte did not reach the update stage");

    a_one_store_op: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_reg.cb_op && s1_reg.cr_op))
        else $error("byte updates both chroma stores");
`endif

endmodule

// File: sv/yuv9p_ram.sv
`timescale 1ns / 1ps

module yuv9p_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: dv/yuv9_plane_checker.sv
`timescale 1ns / 1ps

module yuv9_plane_checker
    import yuv9p_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  in_item_t          in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  out_item_t         out_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [CFGD_W-1:0] cfg_data,
    output int                fail_count,
    output int                pending_samples
);

    logic [1:0]        layout_reg;
    logic [CFGD_W-1:0] width_reg;
    logic [SUM_W-1:0]  cb_store [STORE_DEPTH];
    logic [SUM_W-1:0]  cr_store [STORE_DEPTH];
    int                row_pos;
    logic [1:0]        band_row;
    out_item_t         planned_samples[$];
    int                mismatch_total = 0;

    initial
    begin
        foreach (cb_store[i])
        begin
            cb_store[i] = '0;
            cr_store[i] = '0;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_total++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic out_item_t make_sample(input logic [1:0] plane, input logic [7:0] value);
        out_item_t s;
        s.plane  = plane;
        s.sample = value;
        s.last   = 1'b0;
        return s;
    endfunction

    // The first chroma byte of a column in band row 0 replaces the stale sum.
    function automatic logic [SUM_W-1:0] fold(input logic [SUM_W-1:0] old,
                                              input logic [7:0] value, input logic first);
        return first ? SUM_W'(value) : old + SUM_W'(value);
    endfunction

    task automatic advance_row();
        row_pos  = 0;
        band_row = band_row + 2'd1;
    endtask

    task automatic predict_planes(input in_item_t item);
        logic [1:0] layout;
        int         align;
        int         w;
        int         row_len;
        int         p;
        int         col;
        logic       band_end;
        logic [7:0] d;
        out_item_t  batch[$];
        d = item.data_byte;
        layout = (layout_reg == MODE_422 || layout_reg == MODE_411) ? layout_reg : MODE_GRAY8;
        align = (layout == MODE_411) ? 8 : 4;
        if (item.frame_start)
        begin
            row_pos  = 0;
            band_row = 2'd0;
        end
        w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        w = w - (w % align);
        if (w < align)
            w = align;
        case (layout)
            MODE_GRAY8: row_len = w;
            MODE_422:   row_len = 2 * w;
            default:    row_len = (w / 2) * 3;
        endcase
        // A narrower width can leave the position past the end of the row.
        if (row_pos >= row_len)
            advance_row();
        band_end = (band_row == LAST_BAND_ROW);

        case (layout)
            MODE_GRAY8:
            begin
                batch.push_back(make_sample(PLANE_Y, d));
                if (band_end && (row_pos % 4) == 3)
                begin
                    batch.push_back(make_sample(PLANE_U, CHROMA_GRAY));
                    batch.push_back(make_sample(PLANE_V, CHROMA_GRAY));
                end
            end
            MODE_422:
            begin
                col = (row_pos >> 3) % STORE_DEPTH;
                p   = row_pos % 8;
                if (p % 2 == 0)
                    batch.push_back(make_sample(PLANE_Y, d));
                else if (p == 1 || p == 5)
                    cb_store[col] = fold(cb_store[col], d, band_row == 2'd0 && p == 1);
                else
                begin
                    cr_store[col] = fold(cr_store[col], d, band_row == 2'd0 && p == 3);
                    if (p == 7 && band_end)
                    begin
                        batch.push_back(make_sample(PLANE_U, 8'(cb_store[col] >> 3)));
                        batch.push_back(make_sample(PLANE_V, 8'(cr_store[col] >> 3)));
                    end
                end
            end
            default:
            begin
                p   = row_pos % 12;
                col = ((row_pos / 12) * 2 + ((p >= 4) ? 1 : 0)) % STORE_DEPTH;
                if (p == 0 || p == 4)
                    cb_store[col] = fold(cb_store[col], d, band_row == 2'd0);
                else if (p == 2 || p == 6)
                begin
                    cr_store[col] = fold(cr_store[col], d, band_row == 2'd0);
                    if (band_end)
                    begin
                        batch.push_back(make_sample(PLANE_U, 8'(cb_store[col] >> 2)));
                        batch.push_back(make_sample(PLANE_V, 8'(cr_store[col] >> 2)));
                    end
                end
                else
                    batch.push_back(make_sample(PLANE_Y, d));
            end
        endcase

        row_pos++;
        if (row_pos >= row_len)
            advance_row();
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            planned_samples.push_back(batch[i]);
    endtask

    task automatic check_sample(input out_item_t got);
        out_item_t want;
        if (planned_samples.size() == 0)
        begin
            report_mismatch("sample with nothing pending", got.sample, -1);
            return;
        end
        want = planned_samples.pop_front();
        if (got.plane != want.plane)
            report_mismatch("plane", got.plane, want.plane);
        if (got.sample != want.sample)
            report_mismatch("sample", got.sample, want.sample);
        if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg = MODE_RESET;
            width_reg  = WIDTH_RESET;
            row_pos    = 0;
            band_row   = 2'd0;
            planned_samples.delete();
            pending_samples <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_sample(out_data);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_INPUT_MODE)
                    layout_reg = cfg_data[1:0];
                else if (cfg_index == REG_LINE_WIDTH)
                    width_reg = cfg_data;
            end
            if (in_valid && in_ready)
                predict_planes(in_data);
            pending_samples <= planned_samples.size();
            fail_count      <= mismatch_total;
        end
    end

endmodule

// File: dv/tb_packed_ycbcr_to_yuv9_planar_top.sv
`timescale 1ns / 1ps

module tb_packed_ycbcr_to_yuv9_planar_top;
    import yuv9p_pkg::*;

    // Layout code 3 has no meaning of its own and behaves as gray8.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_PCT      = 38;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 2000;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = REG_INPUT_MODE;
    logic [CFGD_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending_samples;
    int quiet_cycles  = 0;
    int hold_tickets  = 0;
    int holds_served  = 0;
    bit steady_flow   = 1'b0;

    packed_ycbcr_to_yuv9_planar_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    yuv9_plane_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_samples (pending_samples)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sample sink: random stalls, none while the flow is steady, and on request a long
    // hold-off so the result queue fills and the input stalls.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_tickets != holds_served)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("packed_ycbcr_to_yuv9_planar_top regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic configure(input logic [1:0] layout, input logic [CFGD_W-1:0] width);
        logic [CFGD_W-1:0] mode_word;
        mode_word      = CFGD_W'($urandom);
        mode_word[1:0] = layout;
        cfg_valid <= 1'b1;
        cfg_index <= REG_INPUT_MODE;
        cfg_data  <= mode_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_LINE_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_byte(input in_item_t item);
        if (!steady_flow)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Wait until every predicted sample has left, then let the pipeline settle.
    task automatic drain_planes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_samples != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A raster stream opened by a frame start; with noise, a stray frame start now
    // and then cuts a band short.
    task automatic run_phase(input logic [1:0] layout, input logic [CFGD_W-1:0] width,
                             input int count, input bit steady, input bit hold_output);
        in_item_t item;
        configure(layout, width);
        steady_flow = steady;
        if (hold_output)
            hold_tickets++;
        for (int i = 0; i < count; i++)
        begin
            item.data_byte   = 8'($urandom);
            item.frame_start = (i == 0) || (!steady && $urandom_range(39) == 0);
            push_byte(item);
        end
        drain_planes();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One full gray band at the narrowest width, data at both extremes.
        configure(MODE_UNUSED, 12'd3);
        for (int i = 0; i < 16; i++)
            push_byte('{data_byte: (i % 2) ? 8'hFF : 8'h00, frame_start: (i == 0)});
        drain_planes();

        // Part of a wide row, then a narrower width leaves the position past the row end.
        configure(MODE_422, 12'd640);
        for (int i = 0; i < 8; i++)
            push_byte('{data_byte: 8'hFF, frame_start: (i == 0)});
        drain_planes();
        configure(MODE_422, 12'd4);
        push_byte('{data_byte: 8'h80, frame_start: 1'b0});
        drain_planes();

        run_phase(MODE_422,    12'd4,    48, 1'b1, 1'b0);
        run_phase(MODE_411,    12'd8,    48, 1'b1, 1'b1);
        run_phase(MODE_GRAY8,  12'd4095, 16, 1'b0, 1'b0);
        run_phase(MODE_411,    12'd5,    48, 1'b0, 1'b0);
        run_phase(MODE_422,    12'd2048, 12, 1'b0, 1'b0);
        run_phase(MODE_UNUSED, 12'd6,    32, 1'b0, 1'b0);
        run_phase(MODE_422,    12'd10,   32, 1'b0, 1'b0);

        if (fail_count == 0)
            $display("packed_ycbcr_to_yuv9_planar_top regression: pass");
        else
            $display("packed_ycbcr_to_yuv9_planar_top regression: fail");
        $finish;
    end

endmodule
